// ===== rtl/core/assert_macros.svh =====
// Assertion macros used by the checker file of this block.
// No dependencies; the clock and reset are passed in by the caller.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The property must hold at every rising clock edge outside reset.
`define ASSERT_CLK(name, clk, rst_n, prop) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error("assertion failed: %m");

// The condition must never be true at a rising clock edge outside reset.
`define ASSERT_NEVER(name, clk, rst_n, cond) \
    name: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
        else $error("forbidden condition seen: %m");

`endif

// ===== rtl/core/bin2asc_pkg.sv =====
// Package for the binary to ASCII hex/decimal formatter: widths, format codes,
// controller states, command and status structs and the hex digit table.
// No dependencies.
`timescale 1ns / 1ps

package bin2asc_pkg;

    localparam int VALUE_W      = 64;
    localparam int ACTION_W     = 2;
    localparam int CHAR_W       = 8;
    localparam int NIB_W        = 4;
    localparam int HEX32_DIGITS = 8;
    localparam int HEX64_DIGITS = 16;
    localparam int BCD_DIGITS   = 10;
    localparam int BCD_W        = BCD_DIGITS * NIB_W;
    localparam int DEC_BITS     = 32;
    localparam int REM_W        = 5;
    localparam int BITCNT_W     = 5;

    localparam logic [ACTION_W-1:0] ACT_HEX32 = 2'd0;
    localparam logic [ACTION_W-1:0] ACT_HEX64 = 2'd1;
    localparam logic [ACTION_W-1:0] ACT_DEC32 = 2'd2;

    localparam logic [CHAR_W-1:0] CHAR_ZERO = 8'h30;
    localparam logic [CHAR_W-1:0] CHAR_X    = 8'h78;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DABBLE,
        ST_LOAD_BCD,
        ST_SKIP,
        ST_PREFIX_ZERO,
        ST_PREFIX_X,
        ST_DIGITS
    } state_t;

    typedef enum logic [1:0] {
        SEL_ZERO,
        SEL_X,
        SEL_DIGIT
    } char_sel_t;

    typedef struct packed {
        logic      load;
        logic      dabble;
        logic      load_bcd;
        logic      shift;
        char_sel_t sel;
        logic      last;
    } cmd_t;

    typedef struct packed {
        logic top_zero;
        logic rem_one;
        logic bit_last;
    } stat_t;

    function automatic logic [CHAR_W-1:0] digit_char(input logic [NIB_W-1:0] nib);
        logic [CHAR_W-1:0] ch;
        case (nib)
            4'h0: ch = 8'h30;
            4'h1: ch = 8'h31;
            4'h2: ch = 8'h32;
            4'h3: ch = 8'h33;
            4'h4: ch = 8'h34;
            4'h5: ch = 8'h35;
            4'h6: ch = 8'h36;
            4'h7: ch = 8'h37;
            4'h8: ch = 8'h38;
            4'h9: ch = 8'h39;
            4'ha: ch = 8'h61;
            4'hb: ch = 8'h62;
            4'hc: ch = 8'h63;
            4'hd: ch = 8'h64;
            4'he: ch = 8'h65;
            default: ch = 8'h66;
        endcase
        return ch;
    endfunction

endpackage

// ===== rtl/core/bin2asc_if.sv =====
// Stream interfaces of the formatter: the number channel and the text channel.
// Depends on bin2asc_pkg for the payload widths.
`timescale 1ns / 1ps

interface bin2asc_num_if;
    import bin2asc_pkg::*;

    logic                valid;
    logic                ready;
    logic [VALUE_W-1:0]  value;
    logic [ACTION_W-1:0] action;

    modport source (output valid, value, action, input ready);
    modport sink (input valid, value, action, output ready);
endinterface

interface bin2asc_text_if;
    import bin2asc_pkg::*;

    logic              valid;
    logic              ready;
    logic [CHAR_W-1:0] character;
    logic              last;

    modport source (output valid, character, last, input ready);
    modport sink (input valid, character, last, output ready);
endinterface

// ===== rtl/core/bin2asc_ctrl.sv =====
// Controller state machine of the formatter: sequences the decimal conversion,
// leading zero skip, prefix and digit output. Depends on bin2asc_pkg.
`timescale 1ns / 1ps

module bin2asc_ctrl (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    input  logic [bin2asc_pkg::ACTION_W-1:0] action,
    output logic                          in_ready,
    output logic                          out_valid,
    input  logic                          out_ready,
    input  bin2asc_pkg::stat_t            stat,
    output bin2asc_pkg::cmd_t             cmd
);
    import bin2asc_pkg::*;

    state_t state_reg, state_next;
    logic   dec_reg, dec_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            dec_reg   <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            dec_reg   <= dec_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        dec_next   = dec_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    dec_next = (action == ACT_DEC32);
                    if (action inside {ACT_HEX32, ACT_HEX64})
                        state_next = ST_SKIP;
                    else if (action == ACT_DEC32)
                        state_next = ST_DABBLE;
                end
            end
            ST_DABBLE:
            begin
                if (stat.bit_last)
                    state_next = ST_LOAD_BCD;
            end
            ST_LOAD_BCD:
                state_next = ST_SKIP;
            ST_SKIP:
            begin
                if (!stat.top_zero || stat.rem_one)
                    state_next = dec_reg ? ST_DIGITS : ST_PREFIX_ZERO;
            end
            ST_PREFIX_ZERO:
            begin
                if (out_ready)
                    state_next = ST_PREFIX_X;
            end
            ST_PREFIX_X:
            begin
                if (out_ready)
                    state_next = ST_DIGITS;
            end
            ST_DIGITS:
            begin
                if (out_ready && stat.rem_one)
                    state_next = ST_IDLE;
            end
            default:
                state_next = ST_IDLE;
        endcase
    end

    always_comb
    begin
        in_ready     = (state_reg == ST_IDLE);
        out_valid    = state_reg inside {ST_PREFIX_ZERO, ST_PREFIX_X, ST_DIGITS};
        cmd.load     = (state_reg == ST_IDLE) && in_valid;
        cmd.dabble   = (state_reg == ST_DABBLE);
        cmd.load_bcd = (state_reg == ST_LOAD_BCD);
        // Leading zero digits are dropped one per cycle; printed digits advance
        // on each completed text transaction.
        cmd.shift    = ((state_reg == ST_SKIP) && stat.top_zero && !stat.rem_one)
                       || ((state_reg == ST_DIGITS) && out_ready);
        cmd.last     = (state_reg == ST_DIGITS) && stat.rem_one;
        case (state_reg)
            ST_PREFIX_ZERO: cmd.sel = SEL_ZERO;
            ST_PREFIX_X:    cmd.sel = SEL_X;
            default:        cmd.sel = SEL_DIGIT;
        endcase
    end

endmodule

// ===== rtl/core/bin2asc_dp.sv =====
// Datapath of the formatter: digit shift register, bit-serial double dabble
// and character selection. Depends on bin2asc_pkg.
`timescale 1ns / 1ps

module bin2asc_dp (
    input  logic                             clk,
    input  logic [bin2asc_pkg::VALUE_W-1:0]  value,
    input  logic [bin2asc_pkg::ACTION_W-1:0] action,
    input  bin2asc_pkg::cmd_t                cmd,
    output bin2asc_pkg::stat_t               stat,
    output logic [bin2asc_pkg::CHAR_W-1:0]   character,
    output logic                             last
);
    import bin2asc_pkg::*;

    // While digits are output, the next digit to print sits in the top nibble of val_reg.
    logic [VALUE_W-1:0]  val_reg, val_next;
    logic [BCD_W-1:0]    bcd_reg, bcd_next;
    logic [BCD_W-1:0]    bcd_adj;
    logic [BITCNT_W-1:0] bit_cnt_reg, bit_cnt_next;
    logic [REM_W-1:0]    rem_reg, rem_next;

    always_comb
    begin
        for (int i = 0; i < BCD_DIGITS; i++)
        begin
            bcd_adj[i*NIB_W +: NIB_W] = (bcd_reg[i*NIB_W +: NIB_W] >= 4'd5)
                                      ? bcd_reg[i*NIB_W +: NIB_W] + 4'd3
                                      : bcd_reg[i*NIB_W +: NIB_W];
        end
    end

    always_comb
    begin
        val_next     = val_reg;
        bcd_next     = bcd_reg;
        bit_cnt_next = bit_cnt_reg;
        rem_next     = rem_reg;
        if (cmd.load)
        begin
            bcd_next     = '0;
            bit_cnt_next = '0;
            case (action)
                ACT_HEX32:
                begin
                    val_next = {value[DEC_BITS-1:0], {(VALUE_W-DEC_BITS){1'b0}}};
                    rem_next = REM_W'(HEX32_DIGITS);
                end
                ACT_HEX64:
                begin
                    val_next = value;
                    rem_next = REM_W'(HEX64_DIGITS);
                end
                ACT_DEC32:
                begin
                    val_next = {value[DEC_BITS-1:0], {(VALUE_W-DEC_BITS){1'b0}}};
                    rem_next = REM_W'(BCD_DIGITS);
                end
                default:
                begin
                    val_next = val_reg;
                    rem_next = rem_reg;
                end
            endcase
        end
        else if (cmd.dabble)
        begin
            bcd_next     = {bcd_adj[BCD_W-2:0], val_reg[VALUE_W-1]};
            val_next     = {val_reg[VALUE_W-2:0], 1'b0};
            bit_cnt_next = bit_cnt_reg + 1'b1;
        end
        else if (cmd.load_bcd)
        begin
            val_next = {bcd_reg, {(VALUE_W-BCD_W){1'b0}}};
            rem_next = REM_W'(BCD_DIGITS);
        end
        else if (cmd.shift)
        begin
            val_next = {val_reg[VALUE_W-NIB_W-1:0], {NIB_W{1'b0}}};
            rem_next = rem_reg - 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        val_reg     <= val_next;
        bcd_reg     <= bcd_next;
        bit_cnt_reg <= bit_cnt_next;
        rem_reg     <= rem_next;
    end

    assign stat.top_zero = (val_reg[VALUE_W-1 -: NIB_W] == '0);
    assign stat.rem_one  = (rem_reg == REM_W'(1));
    assign stat.bit_last = (bit_cnt_reg == BITCNT_W'(DEC_BITS - 1));

    always_comb
    begin
        case (cmd.sel)
            SEL_ZERO: character = CHAR_ZERO;
            SEL_X:    character = CHAR_X;
            default:  character = digit_char(val_reg[VALUE_W-1 -: NIB_W]);
        endcase
    end

    assign last = cmd.last;

endmodule

// ===== rtl/core/binary_to_ascii_hex_dec.sv =====
// Binary to ASCII hex/decimal formatter, one number at a time.
// Hex: leading zero digits are skipped, then 2 prefix characters and the digits.
// Decimal: double dabble conversion and a BCD load, leading zero skip, then the digits.
// Text follows the number transaction once these steps are done; one character per cycle
// while the sink is ready; the next number is taken the cycle after the last character.
// Async active-low reset returns to idle.
`timescale 1ns / 1ps

module binary_to_ascii_hex_dec (
    input logic            clk,
    input logic            rst_n,
    bin2asc_num_if.sink    number,
    bin2asc_text_if.source text
);
    import bin2asc_pkg::*;

    cmd_t  cmd;
    stat_t stat;

    bin2asc_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (number.valid),
        .action    (number.action),
        .in_ready  (number.ready),
        .out_valid (text.valid),
        .out_ready (text.ready),
        .stat      (stat),
        .cmd       (cmd)
    );

    bin2asc_dp u_dp (
        .clk       (clk),
        .value     (number.value),
        .action    (number.action),
        .cmd       (cmd),
        .stat      (stat),
        .character (text.character),
        .last      (text.last)
    );

endmodule

// ===== rtl/core/bin2asc_chk.sv =====
// Port-level checker for the formatter, attached to the top level by bind.
// Depends on bin2asc_pkg and assert_macros.svh.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module bin2asc_chk (
    input logic                             clk,
    input logic                             rst_n,
    input logic                             number_valid,
    input logic                             number_ready,
    input logic [bin2asc_pkg::ACTION_W-1:0] number_action,
    input logic                             text_valid,
    input logic                             text_ready,
    input logic [bin2asc_pkg::CHAR_W-1:0]   text_character,
    input logic                             text_last
);
    import bin2asc_pkg::*;

    logic            num_xfer;
    logic            text_xfer;
    logic            unused_xfer;
    logic            text_stall;
    logic [CHAR_W:0] text_payload;

    assign num_xfer     = number_valid && number_ready;
    assign text_xfer    = text_valid && text_ready;
    assign unused_xfer  = num_xfer && !(number_action inside {ACT_HEX32, ACT_HEX64, ACT_DEC32});
    assign text_stall   = text_valid && !text_ready;
    assign text_payload = {text_character, text_last};

    // A number is taken only when no text of an earlier number is pending.
    `ASSERT_NEVER(a_no_overlap, clk, rst_n, number_ready && text_valid)
    // An unused format code produces no text and leaves the block idle.
    `ASSERT_CLK(a_unused_idle, clk, rst_n, unused_xfer |=> (number_ready && !text_valid))
    // After the final character of a text the block is ready for a new number.
    `ASSERT_CLK(a_last_frees, clk, rst_n, (text_xfer && text_last) |=> number_ready)
    // A stalled text transaction keeps its payload.
    `ASSERT_CLK(a_text_hold, clk, rst_n, text_stall |=> (text_valid && $stable(text_payload)))

endmodule

bind binary_to_ascii_hex_dec bin2asc_chk u_chk (
    .clk            (clk),
    .rst_n          (rst_n),
    .number_valid   (number.valid),
    .number_ready   (number.ready),
    .number_action  (number.action),
    .text_valid     (text.valid),
    .text_ready     (text.ready),
    .text_character (text.character),
    .text_last      (text.last)
);

// ===== tb/tb_binary_to_ascii_hex_dec.sv =====
// Self-checking testbench for binary_to_ascii_hex_dec: predicts the ASCII text of each
// accepted number and checks every character and last flag in order.
// Depends on bin2asc_pkg, the bin2asc stream interfaces and the formatter RTL.
`timescale 1ns / 1ps

module tb_binary_to_ascii_hex_dec;
    import bin2asc_pkg::*;

    localparam logic [ACTION_W-1:0] ACT_UNUSED = 2'd3;
    localparam int HOLD_CYCLES    = 400;
    localparam int WATCHDOG_LIMIT = 5000;
    localparam int DRAIN_CYCLES   = 60;

    typedef struct packed {
        logic [CHAR_W-1:0] character;
        logic              last;
    } text_beat_t;

    logic clk = 1'b0;
    logic rst_n;

    bin2asc_num_if  num_ch ();
    bin2asc_text_if txt_ch ();

    binary_to_ascii_hex_dec i_dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .number (num_ch),
        .text   (txt_ch)
    );

    text_beat_t expected_text[$];
    int         error_count  = 0;
    int         quiet_cycles = 0;
    bit         src_idle_en  = 1'b1;
    bit         sink_idle_en = 1'b1;
    bit         hold_pending = 1'b0;

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Builds the text that one number should produce and queues it character by character.
    function automatic void queue_formatted_text(input logic [VALUE_W-1:0] v,
                                                 input logic [ACTION_W-1:0] a);
        logic [CHAR_W-1:0] chars[$];
        logic [CHAR_W-1:0] rev_digits[$];
        logic [3:0]        nib;
        logic [31:0]       dec_val;
        int                nibbles;
        int                top;
        text_beat_t        beat;
        chars.delete();
        rev_digits.delete();
        if (a == ACT_HEX32 || a == ACT_HEX64)
        begin
            nibbles = (a == ACT_HEX32) ? HEX32_DIGITS : HEX64_DIGITS;
            top = 1;
            for (int k = 0; k < nibbles; k++)
            begin
                if (v[4*k +: 4] != 4'h0)
                    top = k + 1;
            end
            chars.push_back(8'h30);
            chars.push_back(8'h78);
            for (int k = top - 1; k >= 0; k--)
            begin
                nib = v[4*k +: 4];
                chars.push_back((nib < 4'd10) ? (8'h30 + nib) : (8'h61 + nib - 8'd10));
            end
        end
        else if (a == ACT_DEC32)
        begin
            dec_val = v[31:0];
            do
            begin
                rev_digits.push_back(8'h30 + CHAR_W'(dec_val % 10));
                dec_val = dec_val / 10;
            end
            while (dec_val != 0);
            while (rev_digits.size() > 0)
                chars.push_back(rev_digits.pop_back());
        end
        for (int i = 0; i < chars.size(); i++)
        begin
            beat.character = chars[i];
            beat.last      = (i == chars.size() - 1);
            expected_text.push_back(beat);
        end
    endfunction

    // Number channel monitor: every accepted transaction feeds the predictor.
    always @(posedge clk)
    begin
        if (rst_n && num_ch.valid && num_ch.ready)
            queue_formatted_text(num_ch.value, num_ch.action);
    end

    // Text channel checker.
    always @(posedge clk)
    begin
        text_beat_t want;
        if (rst_n && txt_ch.valid && txt_ch.ready)
        begin
            if (expected_text.size() == 0)
            begin
                $error("unexpected character: actual %h last %b", txt_ch.character, txt_ch.last);
                error_count++;
            end
            else
            begin
                want = expected_text.pop_front();
                if (txt_ch.character !== want.character)
                begin
                    $error("character: expected %h, actual %h", want.character, txt_ch.character);
                    error_count++;
                end
                if (txt_ch.last !== want.last)
                begin
                    $error("last: expected %b, actual %b", want.last, txt_ch.last);
                    error_count++;
                end
            end
        end
    end

    // Stall detector: ends the run if no transaction completes for too long.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((num_ch.valid && num_ch.ready) || (txt_ch.valid && txt_ch.ready))
                quiet_cycles <= 0;
            else
                quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= WATCHDOG_LIMIT)
            begin
                $display("Regression FAIL");
                $finish;
            end
        end
    end

    // Text receiver: random stall bursts, plus one long hold-off when requested.
    initial
    begin
        txt_ch.ready = 1'b0;
        wait (rst_n === 1'b1);
        @(posedge clk);
        forever
        begin
            if (hold_pending)
            begin
                hold_pending = 1'b0;
                txt_ch.ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
            end
            else if (sink_idle_en && $urandom_range(0, 3) == 0)
            begin
                txt_ch.ready <= 1'b0;
                repeat ($urandom_range(1, 16)) @(posedge clk);
            end
            else
            begin
                txt_ch.ready <= 1'b1;
                @(posedge clk);
            end
        end
    end

    // Offers one number and returns at the edge where the transaction completes.
    task automatic send_number(input logic [VALUE_W-1:0] v, input logic [ACTION_W-1:0] a);
        if (src_idle_en && $urandom_range(0, 3) == 0)
        begin
            num_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 16)) @(posedge clk);
        end
        num_ch.valid  <= 1'b1;
        num_ch.value  <= v;
        num_ch.action <= a;
        @(posedge clk);
        while (!num_ch.ready)
            @(posedge clk);
    endtask

    function automatic logic [VALUE_W-1:0] random_value();
        logic [VALUE_W-1:0] v;
        int                 nbits;
        v = {$urandom, $urandom};
        nbits = $urandom_range(0, 64);
        if (nbits < 64)
            v &= (64'd1 << nbits) - 64'd1;
        return v;
    endfunction

    function automatic logic [ACTION_W-1:0] random_action();
        int pick;
        pick = $urandom_range(0, 15);
        if (pick < 5)
            return ACT_HEX32;
        else if (pick < 10)
            return ACT_HEX64;
        else if (pick < 15)
            return ACT_DEC32;
        return ACT_UNUSED;
    endfunction

    // Sends count formatted numbers; unused selectors are mixed in but not counted.
    task automatic send_random_numbers(input int count);
        logic [ACTION_W-1:0] a;
        int                  sent;
        sent = 0;
        while (sent < count)
        begin
            a = random_action();
            send_number(random_value(), a);
            if (a != ACT_UNUSED)
                sent++;
        end
    endtask

    task automatic test_directed_extremes();
        send_number(64'd0, ACT_HEX32);
        send_number(64'd0, ACT_HEX64);
        send_number(64'd0, ACT_DEC32);
        send_number({64{1'b1}}, ACT_HEX32);
        send_number({64{1'b1}}, ACT_HEX64);
        send_number({64{1'b1}}, ACT_DEC32);
        // Upper half set with a zero lower half: 32-bit formats must print zero.
        send_number(64'hffff_ffff_0000_0000, ACT_HEX32);
        send_number(64'hffff_ffff_0000_0000, ACT_DEC32);
        send_number(64'hffff_ffff_0000_0000, ACT_HEX64);
        send_number(64'h8000_0000_0000_0000, ACT_HEX64);
        send_number(64'h0000_0000_8000_0000, ACT_HEX32);
        send_number(64'h0000_0000_0000_0001, ACT_HEX64);
        send_number(64'h0123_4567_89ab_cdef, ACT_HEX64);
        send_number(64'hfedc_ba98_7654_3210, ACT_HEX32);
        send_number(64'd9, ACT_DEC32);
        send_number(64'd10, ACT_DEC32);
        send_number(64'd1_000_000_000, ACT_DEC32);
        send_number(64'd999_999_999, ACT_DEC32);
        send_number(64'h0000_0001_0000_0009, ACT_DEC32);
        // The unused selector must produce no text at all.
        send_number({$urandom, $urandom}, ACT_UNUSED);
        send_number(64'd0, ACT_UNUSED);
        send_number(64'd42, ACT_DEC32);
    endtask

    task automatic test_random_mix();
        send_random_numbers(300);
    endtask

    task automatic test_output_hold_off();
        hold_pending = 1'b1;
        send_random_numbers(30);
    endtask

    task automatic test_full_rate();
        src_idle_en  = 1'b0;
        sink_idle_en = 1'b0;
        send_random_numbers(150);
    endtask

    initial
    begin
        num_ch.valid  = 1'b0;
        num_ch.value  = '0;
        num_ch.action = ACT_HEX32;
        rst_n = 1'b0;
        repeat (10) @(posedge clk);
        @(negedge clk) rst_n = 1'b1;
        @(posedge clk);

        test_directed_extremes();
        test_random_mix();
        test_output_hold_off();
        test_full_rate();
        num_ch.valid <= 1'b0;

        while (expected_text.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (error_count == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule

// ===== files.f =====
+incdir+rtl/core
rtl/core/bin2asc_pkg.sv
rtl/core/bin2asc_if.sv
rtl/core/bin2asc_ctrl.sv
rtl/core/bin2asc_dp.sv
rtl/core/binary_to_ascii_hex_dec.sv
rtl/core/bin2asc_chk.sv
tb/tb_binary_to_ascii_hex_dec.sv
